// ===== rtl/core/bsq_pkg.sv =====
`timescale 1ns / 1ps

package bsq_pkg;

	localparam int DEPTH         = 16;
	localparam int DATA_BYTES    = 8;
	localparam int PRIORITY_BITS = 32;

	localparam int DATA_W = 8 * DATA_BYTES;
	localparam int PRIO_W = PRIORITY_BITS;
	localparam int CNT_W  = 5;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);
	localparam logic [CNT_W-1:0] CAP_MAX   = (DEPTH > 31) ? CNT_W'(31) : CNT_W'(DEPTH);

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t item;
	} ctl_t;

endpackage

// ===== rtl/core/bsq_cell.sv =====
`timescale 1ns / 1ps

module bsq_cell (
	input  logic            clk,
	input  bsq_pkg::ctl_t   ctl,
	input  logic            occupied,
	input  logic            force_hold,
	input  logic            prev_hold,
	input  bsq_pkg::entry_t prev_entry,
	input  bsq_pkg::entry_t next_entry,
	output logic            hold,
	output bsq_pkg::entry_t entry
);
	import bsq_pkg::*;

	entry_t entry_q;
	entry_t entry_nxt;

	// A cell keeps its entry on a push when the new request sorts behind it.
	assign hold = force_hold || (occupied && (entry_q.prio < ctl.item.prio));

	always_comb begin
		entry_nxt = entry_q;
		priority if (ctl.push) begin
			if (hold) begin
				entry_nxt = entry_q;
			end else if (prev_hold) begin
				entry_nxt = ctl.item;
			end else begin
				entry_nxt = prev_entry;
			end
		end else if (ctl.pop) begin
			entry_nxt = next_entry;
		end else begin
			entry_nxt = entry_q;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_nxt;
	end

	assign entry = entry_q;

endmodule

// ===== rtl/core/bounded_sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// Each result is registered; every cell of the row compares and shifts in parallel.
// Throughput: one request per cycle while the output is not stalled.
// A new request is taken while the output register is empty or its result is being taken.
// Reset clears the entry count, the output valid flag and sets the capacity limit to 16.
// Entry storage is not cleared; slots beyond the entry count are never reported.

module bounded_sorted_priority_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [63:0] item_data,
	input  logic [31:0] item_priority,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [63:0] out_data,
	output logic [31:0] out_priority,
	output logic [4:0]  entry_total,
	output logic        is_empty
);
	import bsq_pkg::*;

	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             out_valid_q;
	logic [1:0]       status_q;
	entry_t           head_q;
	logic [CNT_W-1:0] total_q;

	ctl_t             ctl;
	logic             fire;
	logic             full;
	logic             push_ok;
	logic             pop_ok;
	logic [1:0]       status_nxt;
	entry_t           head_nxt;
	entry_t           item;

	logic   [DEPTH-1:0] occupied;
	logic   [DEPTH-1:0] hold;
	entry_t             entry [DEPTH];

	assign item.data = item_data[DATA_W-1:0];
	assign item.prio = item_priority[PRIO_W-1:0];

	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;
	assign full     = (count_q >= cap_q) || (count_q >= CAP_MAX);
	assign push_ok  = (operation == OP_PUSH) && !full;
	assign pop_ok   = (operation == OP_POP) && (count_q != '0);

	assign ctl.push = fire && push_ok;
	assign ctl.pop  = fire && pop_ok;
	assign ctl.item = item;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic   force_hold;
			logic   prev_hold;
			entry_t prev_entry;
			entry_t next_entry;

			assign occupied[gi] = (gi < int'(count_q));

			if (gi == 0) begin : g_head
				// An equal priority at the head sends the new entry behind it.
				assign force_hold = occupied[0] && (entry[0].prio == item.prio);
				assign prev_hold  = 1'b1;
				assign prev_entry = item;
			end else begin : g_body
				assign force_hold = 1'b0;
				assign prev_hold  = hold[gi-1];
				assign prev_entry = entry[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_tail
				assign next_entry = entry[gi];
			end else begin : g_mid
				assign next_entry = entry[gi+1];
			end

			bsq_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.occupied   (occupied[gi]),
				.force_hold (force_hold),
				.prev_hold  (prev_hold),
				.prev_entry (prev_entry),
				.next_entry (next_entry),
				.hold       (hold[gi]),
				.entry      (entry[gi])
			);
		end
	endgenerate

	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_OK;
		head_nxt   = '0;
		unique case (operation)
			OP_PUSH: begin
				if (full) begin
					status_nxt = ST_FULL;
					if (count_q != '0) begin
						head_nxt = entry[0];
					end
				end else begin
					count_nxt = count_q + CNT_W'(1);
					head_nxt  = hold[0] ? entry[0] : item;
				end
			end
			OP_POP: begin
				if (count_q == '0) begin
					status_nxt = ST_EMPTY;
				end else begin
					count_nxt = count_q - CNT_W'(1);
					head_nxt  = entry[0];
				end
			end
			default: begin
				if (count_q == '0) begin
					status_nxt = ST_EMPTY;
				end else begin
					head_nxt = entry[0];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (fire) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_nxt;
			head_q   <= head_nxt;
			total_q  <= count_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_data     = 64'(head_q.data);
	assign out_priority = 32'(head_q.prio);
	assign entry_total  = total_q;
	assign is_empty     = (total_q == '0);

endmodule

// ===== rtl/core/bsq_checker.sv =====
`timescale 1ns / 1ps

module bsq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [63:0] out_data,
	input logic [31:0] out_priority,
	input logic [4:0]  entry_total,
	input logic        is_empty
);
	import bsq_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(status))
		else $error("Result changed while stalled.");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("Accepted request produced no result.");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (entry_total == 5'd0)) && (status != 2'd3))
		else $error("Empty flag or status inconsistent.");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY) |-> is_empty && (out_data == 64'd0)
			&& (out_priority == 32'd0))
		else $error("Empty result carries an entry.");

endmodule

bind bounded_sorted_priority_queue bsq_checker u_bsq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.out_data     (out_data),
	.out_priority (out_priority),
	.entry_total  (entry_total),
	.is_empty     (is_empty)
);
